// ===== rtl/fwk2d_pkg.sv =====
// ============================================================================
// fwk2d_pkg: shared types and constants for the 2-D Fenwick range-add store
// Beat payloads, request codes, register indexes and the command/status
// structs that join the controller and the datapath.
// ============================================================================
`default_nettype none

package fwk2d_pkg;

	// field widths
	localparam int COORD_W = 7;
	localparam int WALK_W  = 8;   // walk index: holds hi+1 and idx+lowbit(idx)
	localparam int DELTA_W = 32;
	localparam int DATA_W  = 64;

	// default grid bounds
	localparam int MAX_ROWS_DEF = 64;
	localparam int MAX_COLS_DEF = 64;

	// request codes
	localparam logic [1:0] REQ_ADD   = 2'd0;
	localparam logic [1:0] REQ_QUERY = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 1'b1;
	localparam logic [COORD_W-1:0] CFG_SIZE_RESET = 7'd64;

	typedef struct packed {
		logic [1:0]                req_type;
		logic [COORD_W-1:0]        row_lo;
		logic [COORD_W-1:0]        col_lo;
		logic [COORD_W-1:0]        row_hi;
		logic [COORD_W-1:0]        col_hi;
		logic signed [DELTA_W-1:0] delta;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] cell_value;
		logic                     status;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic latch;        // capture request beat
		logic corner_init;  // load walk start for current corner
		logic corner_next;  // move to next corner
		logic add_row;      // upward row step
		logic add_col;      // write read-modify-write word, upward column step
		logic q_row;        // downward row step
		logic q_col;        // accumulate word, downward column step
		logic clr_step;     // clear one word
		logic out_load;     // load result register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] req_type;
		logic       oob;
		logic       corner_skip;
		logic       corner_last;
		logic       col_over;
		logic       row_zero;
		logic       col_zero;
		logic       clr_last;
	} sts_t;

	function automatic logic [WALK_W-1:0] low_bit(input logic [WALK_W-1:0] x);
		return x & (~x + WALK_W'(1));
	endfunction

endpackage

`default_nettype wire

// ===== rtl/fwk2d_ram.sv =====
// ============================================================================
// fwk2d_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ============================================================================
`default_nettype none

module fwk2d_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/fwk2d_dp.sv =====
// ============================================================================
// fwk2d_dp: datapath of the 2-D Fenwick range-add store
// Size registers, request capture, row/column walk indexes, tree memory,
// read-modify-write adder, query accumulator and result register.
// ============================================================================
`default_nettype none

module fwk2d_dp #(
	parameter int MAX_ROWS = fwk2d_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = fwk2d_pkg::MAX_COLS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [fwk2d_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [fwk2d_pkg::COORD_W-1:0]       cfg_data,
	input  wire fwk2d_pkg::req_t                     req,
	input  wire fwk2d_pkg::cmd_t                     cmd,
	output fwk2d_pkg::sts_t                          sts,
	output fwk2d_pkg::rsp_t                          rsp
);

	localparam int WW    = fwk2d_pkg::WALK_W;
	localparam int DW    = fwk2d_pkg::DATA_W;
	localparam int CW    = fwk2d_pkg::COORD_W;
	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = AW + WW;

	logic [CW-1:0] num_rows_q, num_cols_q;
	logic [WW-1:0] eff_r, eff_c;

	logic [1:0]    req_q;
	logic [WW-1:0] r0_q, c0_q, r1_q, c1_q;
	logic [DW-1:0] d_q;
	logic          oob_q;
	logic [1:0]    k_q;
	logic [WW-1:0] rr_q, cc_q, cs_q;
	logic [DW-1:0] acc_q;
	logic [AW-1:0] clr_q;
	fwk2d_pkg::rsp_t rsp_q;

	logic [WW-1:0] row_start, col_start;
	logic [WW-1:0] row_idx, col_idx;
	logic [PW-1:0] addr_full;
	logic [AW-1:0] addr;
	logic          corner_neg;
	logic [DW-1:0] addend, sum;
	logic [DW-1:0] rdata;
	logic          we;
	logic [AW-1:0] waddr;
	logic [DW-1:0] wdata;
	logic [WW-1:0] in_r0, in_c0, in_r1, in_c1;
	logic          in_oob;
	logic          clr_last;

	// clamp size registers to one..max
	always_comb begin
		if (num_rows_q == '0) begin
			eff_r = WW'(1);
		end else if (int'(num_rows_q) > MAX_ROWS) begin
			eff_r = WW'(MAX_ROWS);
		end else begin
			eff_r = WW'(num_rows_q);
		end
		if (num_cols_q == '0) begin
			eff_c = WW'(1);
		end else if (int'(num_cols_q) > MAX_COLS) begin
			eff_c = WW'(MAX_COLS);
		end else begin
			eff_c = WW'(num_cols_q);
		end
	end

	// bounds check of the incoming beat
	assign in_r0 = WW'(req.row_lo);
	assign in_c0 = WW'(req.col_lo);
	assign in_r1 = WW'(req.row_hi);
	assign in_c1 = WW'(req.col_hi);

	always_comb begin
		case (req.req_type)
			fwk2d_pkg::REQ_ADD: begin
				in_oob = (in_r0 > eff_r) || (in_r1 > eff_r) ||
					(in_c0 > eff_c) || (in_c1 > eff_c);
			end
			fwk2d_pkg::REQ_QUERY: begin
				in_oob = (in_r0 > eff_r) || (in_c0 > eff_c);
			end
			default: begin
				in_oob = 1'b0;
			end
		endcase
	end

	// corner start: bit 0 picks row_hi+1, bit 1 picks col_hi+1
	assign row_start  = k_q[0] ? (r1_q + WW'(1)) : r0_q;
	assign col_start  = k_q[1] ? (c1_q + WW'(1)) : c0_q;
	assign corner_neg = k_q[0] ^ k_q[1];

	// word address of (rr, cc)
	assign row_idx   = rr_q - WW'(1);
	assign col_idx   = cc_q - WW'(1);
	assign addr_full = PW'(row_idx) * PW'(MAX_COLS) + PW'(col_idx);
	assign addr      = addr_full[AW-1:0];

	// read-modify-write adder, negate via invert and carry in
	assign addend = corner_neg ? ~d_q : d_q;
	assign sum    = rdata + addend + DW'(corner_neg);

	assign clr_last = (clr_q == AW'(DEPTH - 1));

	assign we    = cmd.add_col | cmd.clr_step;
	assign waddr = cmd.clr_step ? clr_q : addr;
	assign wdata = cmd.clr_step ? '0 : sum;

	fwk2d_ram #(
		.WIDTH(DW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (addr),
		.rdata (rdata)
	);

	// control registers: sizes, corner index, clear pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= fwk2d_pkg::CFG_SIZE_RESET;
			num_cols_q <= fwk2d_pkg::CFG_SIZE_RESET;
			k_q        <= '0;
			clr_q      <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					fwk2d_pkg::CFG_NUM_ROWS: num_rows_q <= cfg_data;
					fwk2d_pkg::CFG_NUM_COLS: num_cols_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.latch) begin
				k_q <= '0;
			end else if (cmd.corner_next) begin
				k_q <= k_q + 2'd1;
			end
			if (cmd.clr_step) begin
				clr_q <= clr_last ? '0 : clr_q + AW'(1);
			end
		end
	end

	// payload registers: request, walk indexes, accumulator, result
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= req.req_type;
			r0_q  <= in_r0;
			c0_q  <= in_c0;
			r1_q  <= in_r1;
			c1_q  <= in_c1;
			d_q   <= {{(DW - fwk2d_pkg::DELTA_W){req.delta[fwk2d_pkg::DELTA_W-1]}},
				req.delta};
			oob_q <= in_oob;
			acc_q <= '0;
			rr_q  <= in_r0;
			cc_q  <= in_c0;
			cs_q  <= in_c0;
		end else if (cmd.corner_init) begin
			rr_q <= row_start;
			cc_q <= col_start;
			cs_q <= col_start;
		end else if (cmd.add_row) begin
			rr_q <= rr_q + fwk2d_pkg::low_bit(rr_q);
			cc_q <= cs_q;
		end else if (cmd.add_col) begin
			cc_q <= cc_q + fwk2d_pkg::low_bit(cc_q);
		end else if (cmd.q_row) begin
			rr_q <= rr_q - fwk2d_pkg::low_bit(rr_q);
			cc_q <= cs_q;
		end else if (cmd.q_col) begin
			cc_q  <= cc_q - fwk2d_pkg::low_bit(cc_q);
			acc_q <= acc_q + rdata;
		end
		if (cmd.out_load) begin
			rsp_q.cell_value <= $signed(acc_q);
			rsp_q.status     <= oob_q;
		end
	end

	// status to controller
	always_comb begin
		sts.req_type    = req_q;
		sts.oob         = oob_q;
		sts.corner_skip = (cs_q == '0) || (rr_q == '0) || (rr_q > eff_r) || (cs_q > eff_c);
		sts.corner_last = (k_q == 2'd3);
		sts.col_over    = (cc_q > eff_c);
		sts.row_zero    = (rr_q == '0);
		sts.col_zero    = (cc_q == '0);
		sts.clr_last    = clr_last;
	end

	assign rsp = rsp_q;

endmodule

`default_nettype wire

// ===== rtl/fwk2d_ctrl.sv =====
// ============================================================================
// fwk2d_ctrl: controller of the 2-D Fenwick range-add store
// Sequences the reset clearing pass, corner walks, query walks, clear
// requests and the result handshake.
// ============================================================================
`default_nettype none

module fwk2d_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_ready,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	input  wire fwk2d_pkg::sts_t  sts,
	output fwk2d_pkg::cmd_t       cmd
);

	localparam logic [3:0] S_INIT   = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_DECIDE = 4'd2;
	localparam logic [3:0] S_CINIT  = 4'd3;
	localparam logic [3:0] S_ACHK   = 4'd4;
	localparam logic [3:0] S_AWR    = 4'd5;
	localparam logic [3:0] S_QCHK   = 4'd6;
	localparam logic [3:0] S_QACC   = 4'd7;
	localparam logic [3:0] S_CLEAR  = 4'd8;
	localparam logic [3:0] S_DONE   = 4'd9;

	logic [3:0] state_q, state_d;
	logic       rsp_valid_q;

	// next state and commands
	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		req_ready = 1'b0;
		case (state_q)
			S_INIT: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (sts.oob) begin
					state_d = S_DONE;
				end else begin
					case (sts.req_type)
						fwk2d_pkg::REQ_ADD:   state_d = S_CINIT;
						fwk2d_pkg::REQ_QUERY: state_d = S_QCHK;
						fwk2d_pkg::REQ_CLEAR: state_d = S_CLEAR;
						default:              state_d = S_DONE;
					endcase
				end
			end
			S_CINIT: begin
				cmd.corner_init = 1'b1;
				state_d         = S_ACHK;
			end
			S_ACHK: begin
				if (sts.corner_skip) begin
					if (sts.corner_last) begin
						state_d = S_DONE;
					end else begin
						cmd.corner_next = 1'b1;
						state_d         = S_CINIT;
					end
				end else if (sts.col_over) begin
					cmd.add_row = 1'b1;
				end else begin
					state_d = S_AWR;
				end
			end
			S_AWR: begin
				cmd.add_col = 1'b1;
				state_d     = S_ACHK;
			end
			S_QCHK: begin
				if (sts.row_zero) begin
					state_d = S_DONE;
				end else if (sts.col_zero) begin
					cmd.q_row = 1'b1;
				end else begin
					state_d = S_QACC;
				end
			end
			S_QACC: begin
				cmd.q_col = 1'b1;
				state_d   = S_QCHK;
			end
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

	// result register is only overwritten once its beat is gone
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!rsp_valid_q || rsp_ready))
		else $error("result register overwritten while beat pending");

	// a loaded result is offered on the next cycle
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> rsp_valid_q)
		else $error("loaded result not offered");

	// every tree write follows its read cycle
	a_rmw_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_AWR) |-> ($past(state_q) == S_ACHK))
		else $error("tree write without preceding read");

	// an accepted beat always goes to decode
	a_accept_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == S_DECIDE))
		else $error("accepted beat not decoded");

	// no beat taken while memory is being cleared
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INIT || state_q == S_CLEAR) |-> !req_ready)
		else $error("beat accepted during clearing pass");

endmodule

`default_nettype wire

// ===== rtl/fenwick_2d_range_add_point_query.sv =====
// Add: four corner walks, each a read then a write per tree word, then one result beat;
//   query: one downward walk that reads and accumulates words, then one result beat.
// Clear request: zeroes all MAX_ROWS*MAX_COLS words, one word a cycle through the write port.
// Throughput: one item at a time; a new beat is taken only once the last result is loaded.
// Reset: a clearing pass over all MAX_ROWS*MAX_COLS words (4096 by default) zeroes the tree;
//   req_ready stays low until it ends, configuration writes are taken throughout.
// ============================================================================
// fenwick_2d_range_add_point_query: 2-D binary indexed tree store
// Rectangle add by four corner walks, point query by downward walk, clear.
// ============================================================================
`default_nettype none

module fenwick_2d_range_add_point_query #(
	parameter int MAX_ROWS = fwk2d_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = fwk2d_pkg::MAX_COLS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [fwk2d_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [fwk2d_pkg::COORD_W-1:0]   cfg_data,
	input  wire logic                            req_valid,
	output logic                                 req_ready,
	input  wire fwk2d_pkg::req_t                 req,
	output logic                                 rsp_valid,
	input  wire logic                            rsp_ready,
	output fwk2d_pkg::rsp_t                      rsp
);

	fwk2d_pkg::cmd_t cmd;
	fwk2d_pkg::sts_t sts;

	// sequencing
	fwk2d_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// storage and arithmetic
	fwk2d_dp #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for the 2-D Fenwick range-add / point-query store
// Drives rectangle adds, point queries, clears and unknown requests over
// several grid sizes, tracks the grid in a difference-form model of its own,
// and compares every response beat with the value that model predicts.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	import fwk2d_pkg::*;

	localparam logic [1:0] REQ_UNKNOWN = 2'd3;
	localparam int GRID_WORDS = MAX_ROWS_DEF * MAX_COLS_DEF;
	localparam int PHASES = 10;
	localparam int ITEMS_PER_PHASE = 45;
	// clear pass plus every item at clear latency with both sides fully idling, x3
	localparam longint CYCLE_LIMIT =
		3 * (GRID_WORDS + (PHASES * ITEMS_PER_PHASE + 50) * (GRID_WORDS + 3 + 40));

	// Difference-form grid model: predicts each response and checks it
	class fenwick_grid_tracker;
		logic [DATA_W-1:0] diff_words [GRID_WORDS];
		logic [COORD_W-1:0] rows_reg;
		logic [COORD_W-1:0] cols_reg;
		rsp_t queued_results [$];
		int mismatches;

		function new();
			clear_words();
			rows_reg = CFG_SIZE_RESET;
			cols_reg = CFG_SIZE_RESET;
			mismatches = 0;
		endfunction

		function void clear_words();
			foreach (diff_words[i]) diff_words[i] = '0;
		endfunction

		function void write_size(input logic [CFG_IDX_W-1:0] idx,
				input logic [COORD_W-1:0] value);
			if (idx == CFG_NUM_ROWS) rows_reg = value;
			else cols_reg = value;
		endfunction

		function int rows_in_use();
			if (rows_reg == 0) return 1;
			if (rows_reg > MAX_ROWS_DEF) return MAX_ROWS_DEF;
			return rows_reg;
		endfunction

		function int cols_in_use();
			if (cols_reg == 0) return 1;
			if (cols_reg > MAX_COLS_DEF) return MAX_COLS_DEF;
			return cols_reg;
		endfunction

		// Walk up from one corner by lowest set bit, adding d to each word
		function void corner_add(input int r, input int c, input logic [DATA_W-1:0] d);
			int rr;
			int cc;
			int nr;
			int nc;
			nr = rows_in_use();
			nc = cols_in_use();
			if (r == 0 || c == 0) return;
			for (rr = r; rr <= nr; rr += rr & (-rr))
				for (cc = c; cc <= nc; cc += cc & (-cc))
					diff_words[(rr - 1) * MAX_COLS_DEF + (cc - 1)] += d;
		endfunction

		// Apply an accepted request beat and queue the response it must produce
		function void note_request(input req_t item);
			rsp_t res;
			logic [DATA_W-1:0] d;
			int nr;
			int nc;
			int rr;
			int cc;
			nr = rows_in_use();
			nc = cols_in_use();
			res = '0;
			d = {{(DATA_W - DELTA_W){item.delta[DELTA_W-1]}}, item.delta};
			case (item.req_type)
				REQ_ADD: begin
					if (item.row_lo > nr || item.row_hi > nr ||
							item.col_lo > nc || item.col_hi > nc) begin
						res.status = 1'b1;
					end else begin
						corner_add(item.row_lo, item.col_lo, d);
						corner_add(item.row_hi + 1, item.col_lo, -d);
						corner_add(item.row_lo, item.col_hi + 1, -d);
						corner_add(item.row_hi + 1, item.col_hi + 1, d);
					end
				end
				REQ_QUERY: begin
					if (item.row_lo > nr || item.col_lo > nc) begin
						res.status = 1'b1;
					end else begin
						for (rr = item.row_lo; rr != 0; rr -= rr & (-rr))
							for (cc = item.col_lo; cc != 0; cc -= cc & (-cc))
								res.cell_value += diff_words[(rr - 1) * MAX_COLS_DEF + (cc - 1)];
					end
				end
				REQ_CLEAR: begin
					clear_words();
				end
				default: begin
				end
			endcase
			queued_results.push_back(res);
		endfunction

		// Compare one response beat with the oldest queued prediction
		function void check_response(input rsp_t got);
			rsp_t want;
			if (queued_results.size() == 0) begin
				$display("%0t: response beat with none expected, got value %0d status %0b",
					$time, got.cell_value, got.status);
				mismatches++;
				return;
			end
			want = queued_results.pop_front();
			if (got.cell_value !== want.cell_value) begin
				$display("%0t: cell_value mismatch, expected %0d, got %0d",
					$time, want.cell_value, got.cell_value);
				mismatches++;
			end
			if (got.status !== want.status) begin
				$display("%0t: status mismatch, expected %0b, got %0b",
					$time, want.status, got.status);
				mismatches++;
			end
		endfunction

		function int outstanding();
			return queued_results.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COORD_W-1:0] cfg_data = '0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	fenwick_grid_tracker grid = new();
	longint cycle_count = 0;
	bit send_calm = 1'b0;
	bit recv_calm = 1'b0;

	fenwick_2d_range_add_point_query u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Accept response beats after a random stall, then check them
	initial begin
		int stall;
		forever begin
			if ($urandom_range(0, 19) == 0) recv_calm = !recv_calm;
			stall = recv_calm ? 0 : $urandom_range(0, 16);
			repeat (stall) begin
				@(negedge clk);
				rsp_ready <= 1'b0;
			end
			@(negedge clk);
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			grid.check_response(rsp);
		end
	end

	function automatic req_t make_req(input logic [1:0] t, input int r0, input int c0,
			input int r1, input int c1, input logic [DELTA_W-1:0] d);
		req_t item;
		item.req_type = t;
		item.row_lo = COORD_W'(r0);
		item.col_lo = COORD_W'(c0);
		item.row_hi = COORD_W'(r1);
		item.col_hi = COORD_W'(c1);
		item.delta = d;
		return item;
	endfunction

	// Mostly in range, sometimes zero
	function automatic int pick_coord(input int n);
		if ($urandom_range(0, 11) == 0) return 0;
		return $urandom_range(1, n);
	endfunction

	function automatic logic [DELTA_W-1:0] pick_delta();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return DELTA_W'($urandom_range(0, 20)) - DELTA_W'(10);
			default: return $urandom;
		endcase
	endfunction

	// Random request shaped around the grid size now in use
	function automatic req_t random_request(input int nr, input int nc);
		req_t item;
		int kind;
		int r0;
		int c0;
		int r1;
		int c1;
		int tmp;
		kind = $urandom_range(0, 99);
		r0 = pick_coord(nr);
		c0 = pick_coord(nc);
		r1 = (r0 == 0) ? pick_coord(nr) : $urandom_range(r0, nr);
		c1 = (c0 == 0) ? pick_coord(nc) : $urandom_range(c0, nc);
		if (kind < 2) begin
			item = make_req(REQ_CLEAR, $urandom_range(0, 127), $urandom_range(0, 127),
				$urandom_range(0, 127), $urandom_range(0, 127), $urandom);
		end else if (kind < 5) begin
			item = make_req(REQ_UNKNOWN, $urandom_range(0, 127), $urandom_range(0, 127),
				$urandom_range(0, 127), $urandom_range(0, 127), $urandom);
		end else if (kind < 50) begin
			// break a few rectangles: reverse them or push a corner off the grid
			case ($urandom_range(0, 13))
				0: begin
					tmp = r0; r0 = r1; r1 = tmp;
					tmp = c0; c0 = c1; c1 = tmp;
				end
				1: r0 = $urandom_range(0, 127);
				2: c1 = $urandom_range(0, 127);
				3: begin
					r1 = $urandom_range(0, 127);
					c0 = $urandom_range(0, 127);
				end
				default: begin
				end
			endcase
			item = make_req(REQ_ADD, r0, c0, r1, c1, pick_delta());
		end else begin
			if ($urandom_range(0, 9) == 0) begin
				r0 = $urandom_range(0, 127);
				c0 = $urandom_range(0, 127);
			end
			item = make_req(REQ_QUERY, r0, c0, $urandom_range(0, 127),
				$urandom_range(0, 127), $urandom);
		end
		return item;
	endfunction

	// Offer one request beat after a random gap and hold it until taken
	task automatic push_request(input req_t item);
		int gap;
		if ($urandom_range(0, 19) == 0) send_calm = !send_calm;
		gap = send_calm ? 0 : $urandom_range(0, 16);
		repeat (gap) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!req_ready);
		grid.note_request(item);
	endtask

	// Drop valid and wait until every predicted response has come back
	task automatic settle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (grid.outstanding() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_grid_size(input logic [COORD_W-1:0] rows,
			input logic [COORD_W-1:0] cols);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_NUM_ROWS;
		cfg_data <= rows;
		@(negedge clk);
		cfg_index <= CFG_NUM_COLS;
		cfg_data <= cols;
		@(negedge clk);
		cfg_we <= 1'b0;
		grid.write_size(CFG_NUM_ROWS, rows);
		grid.write_size(CFG_NUM_COLS, cols);
	endtask

	initial begin
		logic [COORD_W-1:0] phase_rows [PHASES];
		logic [COORD_W-1:0] phase_cols [PHASES];
		phase_rows = '{7'd1, 7'd0, 7'd127, 7'd64, 7'd1, 7'd5, 7'd127, 7'd8, 7'd3, 7'd100};
		phase_cols = '{7'd1, 7'd0, 7'd127, 7'd1, 7'd64, 7'd37, 7'd0, 7'd8, 7'd20, 7'd64};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed beats on the full 64x64 grid left by reset
		push_request(make_req(REQ_QUERY, 1, 1, 0, 0, '0));
		push_request(make_req(REQ_ADD, 1, 1, 64, 64, 32'h7fff_ffff));
		push_request(make_req(REQ_QUERY, 64, 64, 127, 127, 32'hffff_ffff));
		push_request(make_req(REQ_ADD, 1, 1, 1, 1, 32'h8000_0000));
		push_request(make_req(REQ_QUERY, 1, 1, 0, 0, '0));
		// reversed rectangle
		push_request(make_req(REQ_ADD, 10, 10, 5, 5, 32'd7));
		push_request(make_req(REQ_QUERY, 7, 7, 0, 0, '0));
		push_request(make_req(REQ_QUERY, 10, 10, 0, 0, '0));
		// zero coordinates make their corners no-ops
		push_request(make_req(REQ_ADD, 0, 3, 4, 0, 32'd100));
		push_request(make_req(REQ_QUERY, 0, 5, 0, 0, '0));
		push_request(make_req(REQ_QUERY, 5, 0, 0, 0, '0));
		push_request(make_req(REQ_QUERY, 5, 3, 0, 0, '0));
		// off-grid coordinates
		push_request(make_req(REQ_ADD, 1, 1, 65, 64, 32'd5));
		push_request(make_req(REQ_ADD, 127, 127, 127, 127, 32'hffff_ffff));
		push_request(make_req(REQ_QUERY, 65, 1, 0, 0, '0));
		push_request(make_req(REQ_QUERY, 1, 127, 0, 0, '0));
		push_request(make_req(REQ_UNKNOWN, 127, 127, 127, 127, 32'hffff_ffff));
		push_request(make_req(REQ_QUERY, 64, 1, 0, 0, '0));
		push_request(make_req(REQ_CLEAR, 127, 127, 127, 127, 32'hffff_ffff));
		push_request(make_req(REQ_QUERY, 64, 64, 0, 0, '0));
		push_request(make_req(REQ_ADD, 32, 32, 64, 64, 32'hffff_ffff));
		push_request(make_req(REQ_QUERY, 40, 40, 0, 0, '0));
		settle();

		// Random phases over a spread of grid sizes
		for (int p = 0; p < PHASES; p++) begin
			if (p == PHASES - 2) begin
				phase_rows[p] = $urandom_range(0, 127);
				phase_cols[p] = $urandom_range(0, 127);
			end
			write_grid_size(phase_rows[p], phase_cols[p]);
			repeat (ITEMS_PER_PHASE)
				push_request(random_request(grid.rows_in_use(), grid.cols_in_use()));
			settle();
		end

		repeat (20) @(posedge clk);
		if (grid.mismatches == 0 && grid.outstanding() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
